// ===== rtl/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types and constants for the DXT block texel decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

    // Field widths
    localparam int BLOCK_W   = 64;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 4;
    localparam int CODE_W    = 2;
    localparam int NIBBLE_W  = 4;
    localparam int TEXELS    = 16;
    localparam int PAL_SIZE  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;

    // Default depth of the queue between front and back end
    localparam int DXT_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLICIT_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE     = 1'b1;

    // Alpha mode codes
    localparam logic [1:0] ALPHA_MODE_PUNCH = 2'd1;

    // Colour code that is black (and maybe transparent) in three-colour mode
    localparam logic [CODE_W-1:0] CODE_ALT = 2'd3;

    // Last texel of a block
    localparam logic [TEXEL_W-1:0] TEXEL_LAST = 4'd15;

    // Reciprocal of three in 11-bit fixed point, exact for sums below 2048
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SH  = 11;

    // Where a texel's alpha comes from
    typedef enum logic [1:0] {
        ASRC_OPAQUE = 2'd0,
        ASRC_PUNCH  = 2'd1,
        ASRC_NIBBLE = 2'd2
    } alpha_src_t;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // Classified block, handed from the front end to the back end
    typedef struct packed {
        rgb_t       [PAL_SIZE-1:0] pal;
        logic       [TEXELS-1:0][CODE_W-1:0]   codes;
        logic       [TEXELS-1:0][NIBBLE_W-1:0] nibbles;
        alpha_src_t                alpha_src;
        logic                      code3_clear;
    } blk_desc_t;

    // Queue control driven by the back end
    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

    // 5-bit to 8-bit expansion by replication
    function automatic chan_t expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // 6-bit to 8-bit expansion by replication
    function automatic chan_t expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Divide a sum below 1024 by three with a reciprocal multiply
    function automatic chan_t div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = x * RECIP3;
        return prod[RECIP3_SH+CHAN_W-1:RECIP3_SH];
    endfunction

endpackage

// ===== rtl/dxt_front.sv =====
// ----------------------------------------------------------------------------
// dxt_front
// Holds the configuration registers, accepts blocks, builds the four-entry
// palette and classifies the alpha source of each block.
// ----------------------------------------------------------------------------
module dxt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dxt_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dxt_pkg::BLOCK_W-1:0]   color_block,
    input  logic [dxt_pkg::BLOCK_W-1:0]   alpha_block,
    input  logic                          q_full,
    output logic                          q_push,
    output dxt_pkg::blk_desc_t            q_data
);
    import dxt_pkg::*;

    logic       explicit_alpha_reg;
    logic       explicit_alpha_next;
    logic [1:0] alpha_mode_reg;
    logic [1:0] alpha_mode_next;

    logic [15:0] ea;
    logic [15:0] eb;
    logic        four;
    rgb_t        ca;
    rgb_t        cb;
    rgb_t        i2;
    rgb_t        i3;

    // Configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        explicit_alpha_next = explicit_alpha_reg;
        alpha_mode_next     = alpha_mode_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXPLICIT_ALPHA: explicit_alpha_next = cfg_data[0];
                CFG_ALPHA_MODE:     alpha_mode_next     = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explicit_alpha_reg <= 1'b0;
            alpha_mode_reg     <= 2'd0;
        end
        else
        begin
            explicit_alpha_reg <= explicit_alpha_next;
            alpha_mode_reg     <= alpha_mode_next;
        end
    end

    // Handshake: stall while the queue is full
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Endpoints and colour mode
    assign ea   = color_block[15:0];
    assign eb   = color_block[31:16];
    assign four = (ea > eb) || explicit_alpha_reg;

    assign ca = '{r: expand5(ea[15:11]), g: expand6(ea[10:5]), b: expand5(ea[4:0])};
    assign cb = '{r: expand5(eb[15:11]), g: expand6(eb[10:5]), b: expand5(eb[4:0])};

    // Interpolants per channel
    always_comb
    begin
        logic [9:0] s2r, s2g, s2b, s3r, s3g, s3b;
        logic [8:0] hr, hg, hb;
        s2r = {1'b0, ca.r, 1'b0} + {2'b00, cb.r} + 10'd1;
        s2g = {1'b0, ca.g, 1'b0} + {2'b00, cb.g} + 10'd1;
        s2b = {1'b0, ca.b, 1'b0} + {2'b00, cb.b} + 10'd1;
        s3r = {2'b00, ca.r} + {1'b0, cb.r, 1'b0} + 10'd1;
        s3g = {2'b00, ca.g} + {1'b0, cb.g, 1'b0} + 10'd1;
        s3b = {2'b00, ca.b} + {1'b0, cb.b, 1'b0} + 10'd1;
        hr  = {1'b0, ca.r} + {1'b0, cb.r} + 9'd1;
        hg  = {1'b0, ca.g} + {1'b0, cb.g} + 9'd1;
        hb  = {1'b0, ca.b} + {1'b0, cb.b} + 9'd1;
        if (four)
        begin
            i2 = '{r: div3(s2r), g: div3(s2g), b: div3(s2b)};
            i3 = '{r: div3(s3r), g: div3(s3g), b: div3(s3b)};
        end
        else
        begin
            i2 = '{r: hr[8:1], g: hg[8:1], b: hb[8:1]};
            i3 = '0;
        end
    end

    // Descriptor written into the queue
    always_comb
    begin
        q_data.pal[0]      = ca;
        q_data.pal[1]      = cb;
        q_data.pal[2]      = i2;
        q_data.pal[3]      = i3;
        q_data.codes       = color_block[63:32];
        q_data.nibbles     = alpha_block;
        q_data.code3_clear = !four;
        if (alpha_mode_reg == ALPHA_MODE_PUNCH)
            q_data.alpha_src = ASRC_PUNCH;
        else if (explicit_alpha_reg)
            q_data.alpha_src = ASRC_NIBBLE;
        else
            q_data.alpha_src = ASRC_OPAQUE;
    end

endmodule

// ===== rtl/dxt_queue.sv =====
// ----------------------------------------------------------------------------
// dxt_queue
// Short register queue of classified blocks between front and back end.
// ----------------------------------------------------------------------------
module dxt_queue
#(
    parameter int DEPTH = dxt_pkg::DXT_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dxt_pkg::blk_desc_t push_data,
    output logic               full,
    input  dxt_pkg::q_ctrl_t   ctrl_in,
    output logic               not_empty,
    output dxt_pkg::blk_desc_t pop_data
);
    import dxt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEPTH);

    blk_desc_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_TOP);
    assign not_empty = (count_reg != '0);
    assign do_pop    = ctrl_in.pop && ctrl_in.valid;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_TOP) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_TOP) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/dxt_back.sv =====
// ----------------------------------------------------------------------------
// dxt_back
// Takes one classified block at a time and streams its sixteen texels
// through an output register, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module dxt_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  dxt_pkg::blk_desc_t            q_data,
    output dxt_pkg::q_ctrl_t              q_ctrl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dxt_pkg::TEXEL_W-1:0]   texel_index,
    output logic [dxt_pkg::CHAN_W-1:0]    red,
    output logic [dxt_pkg::CHAN_W-1:0]    green,
    output logic [dxt_pkg::CHAN_W-1:0]    blue,
    output logic [dxt_pkg::CHAN_W-1:0]    alpha,
    output logic                          last
);
    import dxt_pkg::*;

    blk_desc_t          desc_reg;
    logic               busy_reg;
    logic               busy_next;
    logic [TEXEL_W-1:0] cnt_reg;
    logic [TEXEL_W-1:0] cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [TEXEL_W-1:0] index_reg;
    rgb_t               rgb_reg;
    chan_t              alpha_reg;
    logic               last_reg;

    logic               out_adv;
    logic               emit;
    logic               blk_done;
    logic               pop;
    logic [CODE_W-1:0]  code;
    rgb_t               texel_rgb;
    chan_t              texel_alpha;

    // Sequencing
    assign out_adv  = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_adv;
    assign blk_done = emit && (cnt_reg == TEXEL_LAST);
    assign pop      = q_valid && (!busy_reg || blk_done);

    assign q_ctrl.valid = q_valid;
    assign q_ctrl.pop   = pop;

    always_comb
    begin
        busy_next = busy_reg;
        if (pop)
            busy_next = 1'b1;
        else if (blk_done)
            busy_next = 1'b0;
        cnt_next       = emit ? cnt_reg + 1'b1 : cnt_reg;
        out_valid_next = out_adv ? emit : out_valid_reg;
    end

    // Texel lookup
    assign code      = desc_reg.codes[cnt_reg];
    assign texel_rgb = desc_reg.pal[code];

    always_comb
    begin
        unique case (desc_reg.alpha_src)
            ASRC_PUNCH:
                texel_alpha = (code == CODE_ALT && desc_reg.code3_clear) ? 8'd0 : 8'd255;
            ASRC_NIBBLE:
                texel_alpha = {desc_reg.nibbles[cnt_reg], desc_reg.nibbles[cnt_reg]};
            default:
                texel_alpha = 8'd255;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            desc_reg <= q_data;
        if (emit)
        begin
            index_reg <= cnt_reg;
            rgb_reg   <= texel_rgb;
            alpha_reg <= texel_alpha;
            last_reg  <= (cnt_reg == TEXEL_LAST);
        end
    end

    assign out_valid   = out_valid_reg;
    assign texel_index = index_reg;
    assign red         = rgb_reg.r;
    assign green       = rgb_reg.g;
    assign blue        = rgb_reg.b;
    assign alpha       = alpha_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/dxt_block_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// dxt_block_texel_decoder
// Path: block -> queue -> back end descriptor register -> output register.
// Output: one texel per cycle while out_stall is low, sequenced by the back
// end's texel counter; a queue (two entries by default) takes blocks ahead.
// Reset (rst_n, asynchronous): configuration cleared, queue and output empty.
// Decodes BC1/BC2 style 4x4 blocks into sixteen 8-bit RGBA texels.
// ----------------------------------------------------------------------------
module dxt_block_texel_decoder
#(
    parameter int QUEUE_DEPTH = dxt_pkg::DXT_QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dxt_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dxt_pkg::BLOCK_W-1:0]   color_block,
    input  logic [dxt_pkg::BLOCK_W-1:0]   alpha_block,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dxt_pkg::TEXEL_W-1:0]   texel_index,
    output logic [dxt_pkg::CHAN_W-1:0]    red,
    output logic [dxt_pkg::CHAN_W-1:0]    green,
    output logic [dxt_pkg::CHAN_W-1:0]    blue,
    output logic [dxt_pkg::CHAN_W-1:0]    alpha,
    output logic                          last
);
    import dxt_pkg::*;

    logic      q_full;
    logic      q_push;
    blk_desc_t q_wdata;
    blk_desc_t q_rdata;
    logic      q_valid;
    q_ctrl_t   q_ctrl;

    // Front end: configuration, accept, palette build
    dxt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .color_block (color_block),
        .alpha_block (alpha_block),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    // Block queue
    dxt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .ctrl_in   (q_ctrl),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    // Back end: texel stream
    dxt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_ctrl      (q_ctrl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .texel_index (texel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .last        (last)
    );

endmodule

// ===== rtl/dxt_chk.sv =====
// ----------------------------------------------------------------------------
// dxt_chk
// Port-level checks on the texel stream of the block decoder.
// ----------------------------------------------------------------------------
module dxt_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [dxt_pkg::TEXEL_W-1:0]   texel_index,
    input logic [dxt_pkg::CHAN_W-1:0]    red,
    input logic                          last
);
    import dxt_pkg::*;

    // A stalled texel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(texel_index) && $stable(red))
        else $error("stalled texel changed");

    // last marks texel fifteen and nothing else
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (texel_index == TEXEL_LAST)))
        else $error("last flag out of step with texel index");

    // Within a block texels follow without gaps, in order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last
        |=> out_valid && (texel_index == $past(texel_index) + 4'd1))
        else $error("texel sequence broken inside a block");

    // The texel stream starts at texel zero whenever out_valid rises
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (texel_index == '0))
        else $error("block did not start at texel zero");

endmodule

bind dxt_block_texel_decoder dxt_chk u_dxt_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .texel_index (texel_index),
    .red         (red),
    .last        (last)
);
